@@ rtl/iag_pkg.sv @@
// Shared types, register indexes and constants of the im2col address generator.
`timescale 1ns / 1ps

package iag_pkg;

	// Lanes per transaction and the default width of a source offset.
	localparam int unsigned LANES          = 4;
	localparam int unsigned ADDR_WIDTH_DEF = 24;

	// Offset field width on the result and width of the full offset sum.
	localparam int unsigned OFF_W  = 24;
	localparam int unsigned FULL_W = 43;

	// Configuration port geometry.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 13;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDES       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH     = 3'd7;

	// Mask that aligns a group base down to a multiple of four.
	localparam logic [23:0] BASE_ALIGN_MASK = ~24'h3;

	// One input transaction.
	typedef struct packed {
		logic [23:0] group_base;
		logic [15:0] kernel_index;
		logic [24:0] column_end;
	} item_t;

	// One result transaction.
	typedef struct packed {
		logic [23:0] src_offset_0;
		logic [23:0] src_offset_1;
		logic [23:0] src_offset_2;
		logic [23:0] src_offset_3;
		logic        zero_0;
		logic        zero_1;
		logic        zero_2;
		logic        zero_3;
		logic        offset_overflow;
	} result_t;

endpackage

@@ rtl/im2col_address_generator.sv @@
// Top level of the im2col gather address generator: an eleven stage pipeline.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  item     | item_valid / item_stall    | group_base, kernel_index, column_end
//  result   | result_valid / result_stall| four offsets, four zero flags, overflow
//  cfg      | cfg_write                  | cfg_index, cfg_data
//
// One transaction enters per cycle while item_stall is low; its result is offered
// from stage 11 and leaves at an edge where result_stall is low.
// The pipeline runs two 24-step restoring dividers (position by output width,
// kernel index by kernel area then by kernel width), four steps per stage over six
// stages, followed by a lane split, a stride stage, a multiply stage and a sum stage.
// Reset clears all valid bits and loads the register defaults.
// A stalled result holds in the last stage while empty stages upstream keep filling;
// the input stalls only when every stage holds a transaction.
`timescale 1ns / 1ps

module im2col_address_generator #(
	parameter int unsigned ADDR_WIDTH = iag_pkg::ADDR_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  iag_pkg::item_t                   item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output iag_pkg::result_t                 result,
	input  logic                             cfg_write,
	input  logic [iag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [iag_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import iag_pkg::*;

	localparam int unsigned NSTAGE = 11;
	localparam logic [FULL_W-1:0] ADDR_MASK = {FULL_W{1'b1}} >> (FULL_W - ADDR_WIDTH);

	// Divider state: partial remainder and dividend shifting into the quotient.
	typedef struct packed {
		logic [12:0] rem;
		logic [23:0] dq;
	} pdiv_t;

	typedef struct packed {
		logic [7:0]  rem;
		logic [15:0] dq;
	} kdiv_t;

	typedef struct packed {
		pdiv_t       p;
		kdiv_t       k;
		logic [15:0] kch;
		logic [3:0]  endz;
	} dstage_t;

	// Four restoring steps of the position divider.
	function automatic pdiv_t pos_div4(input pdiv_t s, input logic [12:0] d);
		logic [13:0] t;
		pdiv_t       o;
		o = s;
		for (int j = 0; j < 4; j++) begin
			t = {o.rem, o.dq[23]};
			o.dq = {o.dq[22:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				o.dq[0] = 1'b1;
			end
			o.rem = t[12:0];
		end
		return o;
	endfunction

	// Four restoring steps of the kernel index divider.
	function automatic kdiv_t ker_div4(input kdiv_t s, input logic [7:0] d);
		logic [8:0] t;
		kdiv_t      o;
		o = s;
		for (int j = 0; j < 4; j++) begin
			t = {o.rem, o.dq[15]};
			o.dq = {o.dq[14:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				o.dq[0] = 1'b1;
			end
			o.rem = t[7:0];
		end
		return o;
	endfunction

	// Configuration registers.
	logic [12:0] image_width_q;
	logic [12:0] image_height_q;
	logic [3:0]  kernel_width_q;
	logic [3:0]  kernel_height_q;
	logic [7:0]  strides_q;
	logic [3:0]  pad_left_q;
	logic [3:0]  pad_top_q;
	logic [12:0] out_width_q;
	logic [25:0] iwih_q;

	logic [12:0] ow_eff;
	logic [3:0]  kw_eff;
	logic [3:0]  kh_eff;
	logic [7:0]  kxy;

	// Handshake and pipeline registers.
	logic [NSTAGE:1] valid_s;
	logic [NSTAGE:1] adv;

	dstage_t     div_s   [1:7];
	dstage_t     div_nxt [2:7];

	logic [12:0] cx_s8   [LANES];
	logic [23:0] cy_s8   [LANES];
	logic [12:0] cx_nxt  [LANES];
	logic [23:0] cy_nxt  [LANES];
	logic [15:0] kch_s8;
	logic [3:0]  ky_s8;
	logic [3:0]  kx_s8;
	logic [3:0]  endz_s8;

	logic [12:0] x_s9    [LANES];
	logic [12:0] y_s9    [LANES];
	logic [12:0] x_nxt   [LANES];
	logic [12:0] y_nxt   [LANES];
	logic [3:0]  zero_s9;
	logic [3:0]  zero_nxt;
	logic [15:0] kch_s9;

	logic [41:0] p1_s10;
	logic [25:0] p2_s10  [LANES];
	logic [12:0] x_s10   [LANES];
	logic [3:0]  zero_s10;

	result_t     result_s11;
	result_t     res_nxt;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= 13'd1;
			image_height_q  <= 13'd1;
			kernel_width_q  <= 4'd1;
			kernel_height_q <= 4'd1;
			strides_q       <= 8'h11;
			pad_left_q      <= 4'd0;
			pad_top_q       <= 4'd0;
			out_width_q     <= 13'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data;
				REG_KERNEL_WIDTH:  kernel_width_q  <= cfg_data[3:0];
				REG_KERNEL_HEIGHT: kernel_height_q <= cfg_data[3:0];
				REG_STRIDES:       strides_q       <= cfg_data[7:0];
				REG_PAD_LEFT:      pad_left_q      <= cfg_data[3:0];
				REG_PAD_TOP:       pad_top_q       <= cfg_data[3:0];
				REG_OUT_WIDTH:     out_width_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Image plane size, used only late in the pipeline.
	always_ff @(posedge clk) begin
		iwih_q <= {13'd0, image_width_q} * {13'd0, image_height_q};
	end

	// Zero sizes behave as one.
	assign ow_eff = (out_width_q == 13'd0) ? 13'd1 : out_width_q;
	assign kw_eff = (kernel_width_q == 4'd0) ? 4'd1 : kernel_width_q;
	assign kh_eff = (kernel_height_q == 4'd0) ? 4'd1 : kernel_height_q;
	assign kxy    = {4'd0, kw_eff} * {4'd0, kh_eff};

	// A stage loads when it is empty or its contents move on.
	always_comb begin
		adv[NSTAGE] = !valid_s[NSTAGE] || !result_stall;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			adv[k] = !valid_s[k] || adv[k+1];
		end
	end

	assign item_stall   = !adv[1];
	assign result_valid = valid_s[NSTAGE];
	assign result       = result_s11;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (adv[1]) begin
				valid_s[1] <= item_valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (adv[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	// Stage 1: capture the transaction, seed both dividers, check the column end.
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			div_s[1].p.rem <= '0;
			div_s[1].p.dq  <= item.group_base & BASE_ALIGN_MASK;
			div_s[1].k.rem <= '0;
			div_s[1].k.dq  <= item.kernel_index;
			div_s[1].kch   <= '0;
			for (int i = 0; i < LANES; i++) begin
				div_s[1].endz[i] <= !(({1'b0, item.group_base & BASE_ALIGN_MASK}
					+ 25'(i)) < item.column_end);
			end
		end
	end

	// Stages 2 to 7: four divider steps each. The kernel divider switches from
	// kernel area to kernel width at stage 6, reusing the first remainder.
	always_comb begin : div_steps
		dstage_t src;
		kdiv_t   kin;
		kin = '0;
		for (int k = 2; k <= 7; k++) begin
			src = div_s[k-1];
			div_nxt[k].p    = pos_div4(src.p, ow_eff);
			div_nxt[k].endz = src.endz;
			if (k == 6) begin
				kin.rem         = '0;
				kin.dq          = {src.k.rem, 8'd0};
				div_nxt[k].kch  = src.k.dq;
				div_nxt[k].k    = ker_div4(kin, {4'd0, kw_eff});
			end else if (k == 7) begin
				div_nxt[k].kch  = src.kch;
				div_nxt[k].k    = ker_div4(src.k, {4'd0, kw_eff});
			end else begin
				div_nxt[k].kch  = src.kch;
				div_nxt[k].k    = ker_div4(src.k, kxy);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 2; k <= 7; k++) begin
			if (adv[k]) begin
				div_s[k] <= div_nxt[k];
			end
		end
	end

	// Stage 8: each lane adds its index to the column and wraps into the next rows.
	always_comb begin : lane_split
		logic [13:0] c;
		logic [1:0]  w;
		for (int i = 0; i < LANES; i++) begin
			c = {1'b0, div_s[7].p.rem} + 14'(i);
			w = '0;
			for (int j = 0; j < 3; j++) begin
				if (c >= {1'b0, ow_eff}) begin
					c = c - {1'b0, ow_eff};
					w = w + 2'd1;
				end
			end
			cx_nxt[i] = c[12:0];
			cy_nxt[i] = div_s[7].p.dq + {22'd0, w};
		end
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			cx_s8   <= cx_nxt;
			cy_s8   <= cy_nxt;
			kch_s8  <= div_s[7].kch;
			ky_s8   <= div_s[7].k.dq[3:0];
			kx_s8   <= div_s[7].k.rem[3:0];
			endz_s8 <= div_s[7].endz;
		end
	end

	// Stage 9: image coordinates from stride, padding and kernel offset; bounds check.
	always_comb begin : coord_calc
		logic [16:0]        mx;
		logic [27:0]        my;
		logic signed [19:0] xv;
		logic signed [29:0] yv;
		for (int i = 0; i < LANES; i++) begin
			mx = {4'd0, cx_s8[i]} * {13'd0, strides_q[3:0]};
			my = {4'd0, cy_s8[i]} * {24'd0, strides_q[7:4]};
			xv = $signed({3'd0, mx}) - $signed({16'd0, pad_left_q})
				+ $signed({16'd0, kx_s8});
			yv = $signed({2'd0, my}) - $signed({26'd0, pad_top_q})
				+ $signed({26'd0, ky_s8});
			zero_nxt[i] = endz_s8[i] || (xv < 0) || (xv >= $signed({7'd0, image_width_q}))
				|| (yv < 0) || (yv >= $signed({17'd0, image_height_q}));
			x_nxt[i] = xv[12:0];
			y_nxt[i] = yv[12:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			x_s9    <= x_nxt;
			y_s9    <= y_nxt;
			zero_s9 <= zero_nxt;
			kch_s9  <= kch_s8;
		end
	end

	// Stage 10: channel plane offset and row offsets.
	always_ff @(posedge clk) begin
		if (adv[10]) begin
			p1_s10 <= {16'd0, iwih_q} * {26'd0, kch_s9};
			for (int i = 0; i < LANES; i++) begin
				p2_s10[i] <= {13'd0, image_width_q} * {13'd0, y_s9[i]};
			end
			x_s10    <= x_s9;
			zero_s10 <= zero_s9;
		end
	end

	// Stage 11: full offset, address masking and overflow.
	always_comb begin : offset_sum
		logic [FULL_W-1:0] full;
		logic [OFF_W-1:0]  off [LANES];
		logic              ovf;
		ovf = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			full = {1'b0, p1_s10} + {17'd0, p2_s10[i]} + {30'd0, x_s10[i]};
			if (zero_s10[i]) begin
				off[i] = '0;
			end else begin
				off[i] = OFF_W'(full & ADDR_MASK);
				ovf    = ovf || ((full & ~ADDR_MASK) != '0);
			end
		end
		res_nxt.src_offset_0    = off[0];
		res_nxt.src_offset_1    = off[1];
		res_nxt.src_offset_2    = off[2];
		res_nxt.src_offset_3    = off[3];
		res_nxt.zero_0          = zero_s10[0];
		res_nxt.zero_1          = zero_s10[1];
		res_nxt.zero_2          = zero_s10[2];
		res_nxt.zero_3          = zero_s10[3];
		res_nxt.offset_overflow = ovf;
	end

	always_ff @(posedge clk) begin
		if (adv[NSTAGE]) begin
			result_s11 <= res_nxt;
		end
	end

endmodule

@@ rtl/iag_checker.sv @@
// Port checker for the im2col address generator and its bind statement.
`timescale 1ns / 1ps

module iag_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_stall,
	input logic                           result_valid,
	input logic                           result_stall,
	input iag_pkg::result_t               result
);

	// A stalled result transaction stays offered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result transaction keeps its payload.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	// A lane that writes zero carries a zero offset.
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.zero_0 || result.src_offset_0 == 24'd0)
			&& (!result.zero_1 || result.src_offset_1 == 24'd0)
			&& (!result.zero_2 || result.src_offset_2 == 24'd0)
			&& (!result.zero_3 || result.src_offset_3 == 24'd0))
		else $error("zero lane with nonzero offset");

	// Overflow is only reported when some lane reads the image.
	a_ovf_lane: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.offset_overflow
			|-> !(result.zero_0 && result.zero_1 && result.zero_2 && result.zero_3))
		else $error("overflow with every lane zeroed");

	// With no result waiting, the pipeline always has room for a new item.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled with an empty output stage");

endmodule

bind im2col_address_generator iag_checker u_iag_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
